// ===== sv/mel_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, command/status types for the modular exponentiation ladder unit.
// No dependencies.
package mel_pkg;

   localparam int FIELD_W = 64;
   localparam int OPND_W  = 64;
   localparam int CNT_W   = $clog2(OPND_W + 1);

   typedef enum logic [1:0] {
      MUL_REDUCE = 2'd0,
      MUL_INIT   = 2'd1,
      MUL_LADDER = 2'd2
   } mul_mode_type;

   typedef enum logic [1:0] {
      RSP_ERROR  = 2'd0,
      RSP_ONE    = 2'd1,
      RSP_LADDER = 2'd2
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      logic         expo_shift;
      logic         mul_start;
      mul_mode_type mul_mode;
      logic         mul_write;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic expo_zero;
      logic expo_msb;
      logic bits_done;
      logic mul_idle;
   } dp_status_type;

endpackage

// ===== sv/mel_mulmod.sv =====
`timescale 1ns / 1ps
// Shift-add modular multiplier: one multiplier bit per cycle.
// Depends on mel_pkg.
module mel_mulmod
   import mel_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OPND_W-1:0] a_value,
   input  logic [OPND_W-1:0] b_value,
   input  logic [OPND_W-1:0] m_value,
   output logic              idle,
   output logic [OPND_W-1:0] product
);

   logic [OPND_W-1:0] a_ff, a_in;
   logic [OPND_W-1:0] b_ff, b_in;
   logic [OPND_W-1:0] m_ff, m_in;
   logic [OPND_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   logic [OPND_W:0]   dbl_sum;
   logic [OPND_W-1:0] dbl_red;
   logic [OPND_W:0]   add_sum;
   logic [OPND_W-1:0] add_red;

   always_comb begin
      dbl_sum = {1'b0, acc_ff} + {1'b0, acc_ff};
      if (dbl_sum >= {1'b0, m_ff}) begin
         dbl_red = OPND_W'(dbl_sum - {1'b0, m_ff});
      end else begin
         dbl_red = dbl_sum[OPND_W-1:0];
      end
      add_sum = {1'b0, dbl_red} + {1'b0, b_ff};
      if (add_sum >= {1'b0, m_ff}) begin
         add_red = OPND_W'(add_sum - {1'b0, m_ff});
      end else begin
         add_red = add_sum[OPND_W-1:0];
      end
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in    = a_value;
         b_in    = b_value;
         m_in    = m_value;
         acc_in  = '0;
         cnt_in  = CNT_W'(OPND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_in   = {a_ff[OPND_W-2:0], 1'b0};
         acc_in = a_ff[OPND_W-1] ? add_red : dbl_red;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign idle    = ~busy_ff;
   assign product = acc_ff;

endmodule

// ===== sv/mel_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: operand registers, ladder residues, two modular multipliers, result register.
// Depends on mel_pkg and mel_mulmod.
module mel_datapath
   import mel_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [FIELD_W-1:0] req_base_value,
   input  logic [FIELD_W-1:0] req_exponent_value,
   input  logic [FIELD_W-1:0] req_modulus_value,
   output logic               rsp_valid,
   output logic [FIELD_W-1:0] rsp_power_mod,
   output logic               rsp_modulus_zero
);

   logic [OPND_W-1:0]  base_ff, base_in;
   logic [OPND_W-1:0]  expo_ff, expo_in;
   logic [OPND_W-1:0]  mod_ff, mod_in;
   logic [OPND_W-1:0]  r0_ff, r0_in;
   logic [OPND_W-1:0]  r1_ff, r1_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_pm_ff, rsp_pm_in;
   logic               rsp_mz_ff, rsp_mz_in;

   logic [OPND_W-1:0] mul_a_a, mul_a_b, mul_b_op, prod_a, prod_b;
   logic              idle_a, idle_b;
   logic              ladder_bit;

   assign ladder_bit = expo_ff[OPND_W-1];

   always_comb begin
      if (cmd.mul_mode == MUL_REDUCE) begin
         mul_a_a = base_ff;
         mul_a_b = OPND_W'(1);
      end else begin
         mul_a_a = r0_ff;
         mul_a_b = r1_ff;
      end
      if (cmd.mul_mode == MUL_LADDER && ladder_bit) begin
         mul_b_op = r1_ff;
      end else begin
         mul_b_op = r0_ff;
      end
   end

   mel_mulmod u_mul_a (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a_value (mul_a_a),
      .b_value (mul_a_b),
      .m_value (mod_ff),
      .idle    (idle_a),
      .product (prod_a)
   );

   mel_mulmod u_mul_b (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a_value (mul_b_op),
      .b_value (mul_b_op),
      .m_value (mod_ff),
      .idle    (idle_b),
      .product (prod_b)
   );

   always_comb begin
      base_in      = base_ff;
      expo_in      = expo_ff;
      mod_in       = mod_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      left_in      = left_ff;
      rsp_valid_in = 1'b0;
      rsp_pm_in    = rsp_pm_ff;
      rsp_mz_in    = rsp_mz_ff;
      if (cmd.load) begin
         base_in = req_base_value[OPND_W-1:0];
         expo_in = req_exponent_value[OPND_W-1:0];
         mod_in  = req_modulus_value[OPND_W-1:0];
         left_in = CNT_W'(OPND_W);
      end
      if (cmd.expo_shift) begin
         expo_in = {expo_ff[OPND_W-2:0], 1'b0};
         left_in = left_ff - CNT_W'(1);
      end
      if (cmd.mul_write) begin
         case (cmd.mul_mode)
            MUL_REDUCE: begin
               r0_in = prod_a;
            end
            MUL_INIT: begin
               r1_in = prod_b;
            end
            MUL_LADDER: begin
               if (ladder_bit) begin
                  r0_in = prod_a;
                  r1_in = prod_b;
               end else begin
                  r1_in = prod_a;
                  r0_in = prod_b;
               end
            end
            default: begin
               r0_in = r0_ff;
            end
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         case (cmd.rsp_kind)
            RSP_ERROR: begin
               rsp_pm_in = '0;
               rsp_mz_in = 1'b1;
            end
            RSP_ONE: begin
               rsp_pm_in = (mod_ff == OPND_W'(1)) ? '0 : FIELD_W'(1);
               rsp_mz_in = 1'b0;
            end
            RSP_LADDER: begin
               rsp_pm_in = FIELD_W'(r0_ff);
               rsp_mz_in = 1'b0;
            end
            default: begin
               rsp_pm_in = '0;
               rsp_mz_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff   <= base_in;
      expo_ff   <= expo_in;
      mod_ff    <= mod_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      left_ff   <= left_in;
      rsp_pm_ff <= rsp_pm_in;
      rsp_mz_ff <= rsp_mz_in;
   end

   assign status.mod_zero  = (mod_ff == '0);
   assign status.expo_zero = (expo_ff == '0);
   assign status.expo_msb  = ladder_bit;
   assign status.bits_done = (left_ff == '0);
   assign status.mul_idle  = idle_a & idle_b;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_mod    = rsp_pm_ff;
   assign rsp_modulus_zero = rsp_mz_ff;

endmodule

// ===== sv/mel_control.sv =====
`timescale 1ns / 1ps
// Sequencer for the ladder: checks, exponent normalize, reduce, init square, ladder steps.
// Depends on mel_pkg.
module mel_control
   import mel_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b0000000001,
      ST_CHECK      = 10'b0000000010,
      ST_NORM       = 10'b0000000100,
      ST_RED_START  = 10'b0000001000,
      ST_RED_WAIT   = 10'b0000010000,
      ST_INIT_START = 10'b0000100000,
      ST_INIT_WAIT  = 10'b0001000000,
      ST_LOOP       = 10'b0010000000,
      ST_STEP_START = 10'b0100000000,
      ST_STEP_WAIT  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_mode = MUL_LADDER;
      cmd.rsp_kind = RSP_LADDER;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.mod_zero) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RSP_ERROR;
               state_in     = ST_IDLE;
            end else if (status.expo_zero) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RSP_ONE;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // shift up to the top set bit, then once more to drop it
            cmd.expo_shift = 1'b1;
            if (status.expo_msb) begin
               state_in = ST_RED_START;
            end
         end
         ST_RED_START: begin
            cmd.mul_start = 1'b1;
            cmd.mul_mode  = MUL_REDUCE;
            state_in      = ST_RED_WAIT;
         end
         ST_RED_WAIT: begin
            cmd.mul_mode = MUL_REDUCE;
            if (status.mul_idle) begin
               cmd.mul_write = 1'b1;
               state_in      = ST_INIT_START;
            end
         end
         ST_INIT_START: begin
            cmd.mul_start = 1'b1;
            cmd.mul_mode  = MUL_INIT;
            state_in      = ST_INIT_WAIT;
         end
         ST_INIT_WAIT: begin
            cmd.mul_mode = MUL_INIT;
            if (status.mul_idle) begin
               cmd.mul_write = 1'b1;
               state_in      = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (status.bits_done) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RSP_LADDER;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_STEP_START;
            end
         end
         ST_STEP_START: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_STEP_WAIT;
         end
         ST_STEP_WAIT: begin
            if (status.mul_idle) begin
               cmd.mul_write  = 1'b1;
               cmd.expo_shift = 1'b1;
               state_in       = ST_LOOP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/modular_exponentiation_ladder_unit.sv =====
`timescale 1ns / 1ps
// Top level: modular exponentiation by Montgomery ladder, controller plus datapath.
// Depends on mel_pkg, mel_control, mel_datapath.
//
//   channel   ports                                         transfer when
//   request   start, busy, req_base_value, req_exponent_value,
//             req_modulus_value                             start & !busy
//   response  rsp_valid, rsp_power_mod, rsp_modulus_zero    rsp_valid (one cycle)
//
// One item at a time. Modulus zero or exponent zero: the check state loads the result
// into the response register. Otherwise: normalize, base reduce and first square (one
// multiplier bit per cycle), then one ladder step per exponent bit below the top set bit.
// The two shift-add multipliers set the run time.
// Synchronous active-high reset returns the sequencer to idle; the receiver cannot stall.
module modular_exponentiation_ladder_unit
   import mel_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FIELD_W-1:0] req_base_value,
   input  logic [FIELD_W-1:0] req_exponent_value,
   input  logic [FIELD_W-1:0] req_modulus_value,
   output logic               rsp_valid,
   output logic [FIELD_W-1:0] rsp_power_mod,
   output logic               rsp_modulus_zero
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mel_control u_control (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   mel_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .req_modulus_value  (req_modulus_value),
      .rsp_valid          (rsp_valid),
      .rsp_power_mod      (rsp_power_mod),
      .rsp_modulus_zero   (rsp_modulus_zero)
   );

endmodule

// ===== bench/mel_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the modular exponentiation ladder unit: predicts base^exp mod m per
// accepted request and compares each response transfer in order. Depends on mel_pkg.
module mel_result_checker
   import mel_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [FIELD_W-1:0] req_base_value,
   input  logic [FIELD_W-1:0] req_exponent_value,
   input  logic [FIELD_W-1:0] req_modulus_value,
   input  logic               rsp_valid,
   input  logic [FIELD_W-1:0] rsp_power_mod,
   input  logic               rsp_modulus_zero,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct {
      logic [FIELD_W-1:0] power;
      logic               mod_zero;
   } power_result_type;

   power_result_type expected_power_q[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic [OPND_W-1:0] prod_mod(logic [OPND_W-1:0] a,
                                                  logic [OPND_W-1:0] b,
                                                  logic [OPND_W-1:0] m);
      logic [2*OPND_W-1:0] prod;
      prod = {{OPND_W{1'b0}}, a} * {{OPND_W{1'b0}}, b};
      return OPND_W'(prod % {{OPND_W{1'b0}}, m});
   endfunction

   function automatic power_result_type predict_power_mod(logic [FIELD_W-1:0] b_in,
                                                          logic [FIELD_W-1:0] e_in,
                                                          logic [FIELD_W-1:0] m_in);
      logic [OPND_W-1:0] base, expo, modulus, r0, r1;
      int                top;
      power_result_type  res;
      base         = b_in[OPND_W-1:0];
      expo         = e_in[OPND_W-1:0];
      modulus      = m_in[OPND_W-1:0];
      res.power    = '0;
      res.mod_zero = 1'b0;
      if (modulus == '0) begin
         res.mod_zero = 1'b1;
      end else if (expo == '0) begin
         res.power = FIELD_W'((modulus == 1) ? 0 : 1);
      end else begin
         top = OPND_W - 1;
         while (top > 0 && !expo[top])
            top--;
         r0 = base % modulus;
         r1 = prod_mod(r0, r0, modulus);
         for (int bit_i = top - 1; bit_i >= 0; bit_i--) begin
            if (expo[bit_i]) begin
               r0 = prod_mod(r0, r1, modulus);
               r1 = prod_mod(r1, r1, modulus);
            end else begin
               r1 = prod_mod(r0, r1, modulus);
               r0 = prod_mod(r0, r0, modulus);
            end
         end
         res.power = FIELD_W'(r0);
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      power_result_type want;
      int               errs;
      errs = 0;
      if (!reset) begin
         if (start && !busy)
            expected_power_q.push_back(predict_power_mod(req_base_value,
                                                         req_exponent_value,
                                                         req_modulus_value));
         if (rsp_valid) begin
            if (expected_power_q.size() == 0) begin
               $display("%0t: response with nothing expected: power_mod %h modulus_zero %b",
                        $time, rsp_power_mod, rsp_modulus_zero);
               errs++;
            end else begin
               want = expected_power_q.pop_front();
               if (rsp_power_mod !== want.power) begin
                  $display("%0t: power_mod expected %h actual %h",
                           $time, want.power, rsp_power_mod);
                  errs++;
               end
               if (rsp_modulus_zero !== want.mod_zero) begin
                  $display("%0t: modulus_zero expected %b actual %b",
                           $time, want.mod_zero, rsp_modulus_zero);
                  errs++;
               end
            end
         end
         pending_count <= expected_power_q.size();
         fail_count    <= fail_count + errs;
      end
   end

endmodule

// ===== bench/modular_exponentiation_ladder_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for modular_exponentiation_ladder_unit: drives directed and random requests
// with varying sender gaps and reports the verdict. Depends on mel_pkg, mel_result_checker.
module modular_exponentiation_ladder_unit_tb;
   import mel_pkg::*;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               start              = 1'b0;
   logic               busy;
   logic [FIELD_W-1:0] req_base_value     = '0;
   logic [FIELD_W-1:0] req_exponent_value = '0;
   logic [FIELD_W-1:0] req_modulus_value  = '0;
   logic               rsp_valid;
   logic [FIELD_W-1:0] rsp_power_mod;
   logic               rsp_modulus_zero;
   int                 fail_count;
   int                 pending_count;
   int                 idle_pct           = 0;

   localparam logic [FIELD_W-1:0] ALL_ONES = '1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   modular_exponentiation_ladder_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .req_modulus_value  (req_modulus_value),
      .rsp_valid          (rsp_valid),
      .rsp_power_mod      (rsp_power_mod),
      .rsp_modulus_zero   (rsp_modulus_zero)
   );

   mel_result_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .req_modulus_value  (req_modulus_value),
      .rsp_valid          (rsp_valid),
      .rsp_power_mod      (rsp_power_mod),
      .rsp_modulus_zero   (rsp_modulus_zero),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   function automatic logic [FIELD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [FIELD_W-1:0] rand_bits(int w);
      return rand64() >> (FIELD_W - w);
   endfunction

   // returns at the edge of the transfer
   task automatic send_request(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e,
                               logic [FIELD_W-1:0] m);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < idle_pct);
      end
      start              <= 1'b1;
      req_base_value     <= b;
      req_exponent_value <= e;
      req_modulus_value  <= m;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic send_random();
      logic [FIELD_W-1:0] b, e, m;
      int                 sel;
      sel = $urandom_range(99);
      if (sel < 3)
         m = '0;
      else if (sel < 6)
         m = FIELD_W'(1);
      else if (sel < 14)
         m = ALL_ONES - FIELD_W'($urandom_range(3));
      else
         m = rand_bits($urandom_range(1, FIELD_W));
      sel = $urandom_range(99);
      if (sel < 5)
         e = '0;
      else if (sel < 60)
         e = rand_bits($urandom_range(1, 12));
      else if (sel < 85)
         e = rand_bits($urandom_range(13, 32));
      else
         e = rand64();
      sel = $urandom_range(99);
      if (sel < 50)
         b = rand64();
      else if (sel < 85)
         b = rand_bits($urandom_range(1, FIELD_W));
      else
         b = FIELD_W'($urandom_range(3));
      send_request(b, e, m);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero modulus, zero exponent, unit modulus, small operands, field extremes
      send_request(64'd5, 64'd3, '0);
      send_request(ALL_ONES, ALL_ONES, '0);
      send_request(64'd7, '0, 64'd13);
      send_request(64'd7, '0, 64'd1);
      send_request('0, '0, '0);
      send_request(ALL_ONES, ALL_ONES, 64'd1);
      send_request(64'd9, 64'd1, 64'd1);
      send_request('0, 64'd5, 64'd11);
      send_request(64'd3, 64'd1, 64'd7);
      send_request(64'd3, 64'd2, 64'd7);
      send_request(64'd2, 64'd10, 64'd1000);
      send_request(64'd100, 64'd3, 64'd17);
      send_request(64'd17, 64'd5, 64'd17);
      send_request(ALL_ONES, ALL_ONES, ALL_ONES);
      send_request(ALL_ONES - 1, ALL_ONES, ALL_ONES);
      send_request(ALL_ONES, 64'd2, ALL_ONES - 1);
      send_request(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, ALL_ONES);
      send_request(64'd2, 64'd64, 64'h8000_0000_0000_0001);
      send_request(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'hffff_ffff_ffff_ffc5);
      send_request(64'd3, ALL_ONES, 64'd2);
      send_request(ALL_ONES, 64'd1, 64'd3);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: idle_pct = 0;
            1: idle_pct = 75;
            2: idle_pct = 0;
            default: idle_pct = 34;
         endcase
         repeat (30) send_random();
         if (phase == 1)
            drain_results();
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
